// File: hw/rtl/rwsd_pkg.sv
package rwsd_pkg;

  localparam int HIST_DEPTH = 128;

  localparam int SAMP_W    = 24;
  localparam int MAG_W     = SAMP_W;
  localparam int VAR_W     = 2 * MAG_W;
  localparam int STD_W     = 23;
  localparam int SLOT_W    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int LEN_W     = $clog2(HIST_DEPTH + 1);
  localparam int SUM_W     = SAMP_W + SLOT_W + 1;
  localparam int SQ_W      = 2 * SAMP_W - 1 + SLOT_W;
  localparam int DIV_W     = SQ_W + (SQ_W % 2);
  localparam int DIV_STEPS = DIV_W / 2;
  localparam int SQRT_STEPS = MAG_W;
  localparam int MAX_STEPS = (DIV_STEPS > SQRT_STEPS) ? DIV_STEPS : SQRT_STEPS;
  localparam int CNT_W     = $clog2(MAX_STEPS);

  localparam logic [STD_W-1:0] STD_MAX = {STD_W{1'b1}};

  localparam int WL_W = 8;
  localparam logic [WL_W-1:0] WL_RESET = 8'd114;

  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 3;
  localparam int REG_IDX_W = ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'b0;

  typedef struct packed {
    logic capture;
    logic mem_rd;
    logic add_new;
    logic remove_old;
    logic div_init_sq;
    logic div_init_sum;
    logic div_step;
    logic mul_mean;
    logic var_load;
    logic sqrt_step;
    logic out_load;
  } rwsd_cmd_t;

  typedef struct packed {
    logic full;
  } rwsd_sts_t;

endpackage

// File: hw/rtl/rwsd_ctrl.sv
module rwsd_ctrl import rwsd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output rwsd_cmd_t cmd,
  input  rwsd_sts_t sts
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_SQ_OLD,
    ST_REMOVE,
    ST_DIV_SQ_INIT,
    ST_DIV_SQ,
    ST_DIV_SUM_INIT,
    ST_DIV_SUM,
    ST_MUL_MEAN,
    ST_VAR,
    ST_SQRT,
    ST_FINISH
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;
  logic             div_last;
  logic             sqrt_last;

  assign out_free  = !out_valid_r || out_ready;
  assign div_last  = (cnt_r == CNT_W'(DIV_STEPS - 1));
  assign sqrt_last = (cnt_r == CNT_W'(SQRT_STEPS - 1));
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = '0;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) state_nxt = ST_READ;
      end
      ST_READ: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = ST_SQ_OLD;
      end
      ST_SQ_OLD: begin
        cmd.add_new = 1'b1;
        state_nxt   = ST_REMOVE;
      end
      ST_REMOVE: begin
        cmd.remove_old = 1'b1;
        state_nxt      = sts.full ? ST_DIV_SQ_INIT : ST_FINISH;
      end
      ST_DIV_SQ_INIT: begin
        cmd.div_init_sq = 1'b1;
        state_nxt       = ST_DIV_SQ;
      end
      ST_DIV_SQ: begin
        cmd.div_step = 1'b1;
        if (div_last) begin
          state_nxt = ST_DIV_SUM_INIT;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_DIV_SUM_INIT: begin
        cmd.div_init_sum = 1'b1;
        state_nxt        = ST_DIV_SUM;
      end
      ST_DIV_SUM: begin
        cmd.div_step = 1'b1;
        if (div_last) begin
          state_nxt = ST_MUL_MEAN;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_MUL_MEAN: begin
        cmd.mul_mean = 1'b1;
        state_nxt    = ST_VAR;
      end
      ST_VAR: begin
        cmd.var_load = 1'b1;
        state_nxt    = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (sqrt_last) begin
          state_nxt = ST_FINISH;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_FINISH: begin
        cmd.out_load = out_free;
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (state_r == ST_FINISH && out_free) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_div_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV_SQ || state_r == ST_DIV_SUM) |-> cnt_r < CNT_W'(DIV_STEPS))
    else $error("divider step count out of range");

  a_sqrt_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SQRT) |-> cnt_r < CNT_W'(SQRT_STEPS))
    else $error("root step count out of range");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("result loaded without valid");

endmodule

// File: hw/rtl/rwsd_dp.sv
module rwsd_dp import rwsd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              clear,
  input  logic [WL_W-1:0]   window_length,
  input  logic [SAMP_W-1:0] in_sample,
  input  rwsd_cmd_t         cmd,
  output rwsd_sts_t         sts,
  output logic [STD_W-1:0]  out_std_dev,
  output logic              out_window_full
);

  logic [SAMP_W-1:0] hist_mem [HIST_DEPTH];

  logic [LEN_W-1:0]  win_len;
  logic [SAMP_W-1:0] x_r;
  logic [SAMP_W-1:0] rd_data_r;
  logic [SLOT_W-1:0] slot_r;
  logic              evict_r;
  logic [SLOT_W-1:0] write_slot_r;
  logic [LEN_W-1:0]  fill_r;
  logic [SUM_W-1:0]  sum_r;
  logic [SQ_W-1:0]   sq_r;
  logic [VAR_W-1:0]  prod_r;
  logic [DIV_W-1:0]  div_q_r;
  logic [LEN_W-1:0]  div_rem_r;
  logic [VAR_W-1:0]  mean_sq_r;
  logic [VAR_W-1:0]  sqrt_src_r;
  logic [MAG_W+1:0]  sqrt_rem_r;
  logic [MAG_W-1:0]  root_r;
  logic [STD_W-1:0]  out_std_r;
  logic              out_full_r;

  logic [SLOT_W-1:0] slot_sel;
  logic [LEN_W-1:0]  slot_inc;
  logic [SLOT_W-1:0] next_slot;
  logic [MAG_W-1:0]  x_mag;
  logic [MAG_W-1:0]  old_mag;
  logic [MAG_W-1:0]  mul_a;
  logic [SUM_W-1:0]  x_ext;
  logic [SUM_W-1:0]  old_ext;
  logic [SUM_W-1:0]  sum_mag;
  logic [LEN_W:0]    dr1, dr2;
  logic              b1, b2;
  logic [LEN_W-1:0]  rem1, rem2;
  logic [MAG_W+1:0]  sq_rem_t;
  logic [MAG_W+1:0]  sq_trial;
  logic              sq_ge;
  logic [VAR_W-1:0]  var_val;
  logic [STD_W-1:0]  std_sat;

  always_comb begin
    if (window_length == '0) begin
      win_len = LEN_W'(1);
    end else if (int'(window_length) > HIST_DEPTH) begin
      win_len = LEN_W'(HIST_DEPTH);
    end else begin
      win_len = LEN_W'(window_length);
    end
  end

  assign slot_sel  = (LEN_W'(write_slot_r) >= win_len) ? '0 : write_slot_r;
  assign slot_inc  = LEN_W'(slot_r) + LEN_W'(1);
  assign next_slot = (slot_inc >= win_len) ? '0 : slot_inc[SLOT_W-1:0];

  assign x_mag   = x_r[SAMP_W-1] ? MAG_W'(~x_r + SAMP_W'(1)) : MAG_W'(x_r);
  assign old_mag = rd_data_r[SAMP_W-1] ? MAG_W'(~rd_data_r + SAMP_W'(1))
                                       : MAG_W'(rd_data_r);
  assign x_ext   = {{(SUM_W-SAMP_W){x_r[SAMP_W-1]}}, x_r};
  assign old_ext = {{(SUM_W-SAMP_W){rd_data_r[SAMP_W-1]}}, rd_data_r};
  assign sum_mag = sum_r[SUM_W-1] ? (~sum_r + SUM_W'(1)) : sum_r;

  always_comb begin
    if (cmd.add_new) begin
      mul_a = old_mag;
    end else if (cmd.mul_mean) begin
      mul_a = div_q_r[MAG_W-1:0];
    end else begin
      mul_a = x_mag;
    end
  end

  // radix-4 restoring division by the window length
  always_comb begin
    dr1  = {div_rem_r, div_q_r[DIV_W-1]};
    b1   = (dr1 >= {1'b0, win_len});
    rem1 = b1 ? LEN_W'(dr1 - {1'b0, win_len}) : dr1[LEN_W-1:0];
    dr2  = {rem1, div_q_r[DIV_W-2]};
    b2   = (dr2 >= {1'b0, win_len});
    rem2 = b2 ? LEN_W'(dr2 - {1'b0, win_len}) : dr2[LEN_W-1:0];
  end

  // one root bit per step
  assign sq_rem_t = {sqrt_rem_r[MAG_W-1:0], sqrt_src_r[VAR_W-1:VAR_W-2]};
  assign sq_trial = {root_r, 2'b01};
  assign sq_ge    = (sq_rem_t >= sq_trial);

  assign var_val = (mean_sq_r > prod_r) ? (mean_sq_r - prod_r) : '0;
  assign std_sat = (root_r > MAG_W'(STD_MAX)) ? STD_MAX : root_r[STD_W-1:0];

  assign sts.full        = (fill_r >= win_len);
  assign out_std_dev     = out_std_r;
  assign out_window_full = out_full_r;

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      write_slot_r <= '0;
      fill_r       <= '0;
      sum_r        <= '0;
      sq_r         <= '0;
    end else begin
      if (cmd.add_new) begin
        sum_r        <= sum_r + x_ext;
        sq_r         <= sq_r + SQ_W'(prod_r);
        write_slot_r <= next_slot;
        fill_r       <= evict_r ? win_len : fill_r + LEN_W'(1);
      end
      if (cmd.remove_old && evict_r) begin
        sum_r <= sum_r - old_ext;
        sq_r  <= sq_r - SQ_W'(prod_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      x_r     <= in_sample;
      slot_r  <= slot_sel;
      evict_r <= (fill_r >= win_len);
    end
    if (cmd.mem_rd) begin
      rd_data_r <= hist_mem[slot_r];
    end
    if (cmd.add_new) begin
      hist_mem[slot_r] <= x_r;
    end
    if (cmd.mem_rd || cmd.add_new || cmd.mul_mean) begin
      prod_r <= mul_a * mul_a;
    end
    if (cmd.div_init_sq) begin
      div_q_r   <= DIV_W'(sq_r);
      div_rem_r <= '0;
    end else if (cmd.div_init_sum) begin
      div_q_r   <= DIV_W'(sum_mag);
      div_rem_r <= '0;
      mean_sq_r <= div_q_r[VAR_W-1:0];
    end else if (cmd.div_step) begin
      div_q_r   <= {div_q_r[DIV_W-3:0], b1, b2};
      div_rem_r <= rem2;
    end
    if (cmd.var_load) begin
      sqrt_src_r <= var_val;
      sqrt_rem_r <= '0;
      root_r     <= '0;
    end else if (cmd.sqrt_step) begin
      sqrt_src_r <= {sqrt_src_r[VAR_W-3:0], 2'b00};
      sqrt_rem_r <= sq_ge ? (sq_rem_t - sq_trial) : sq_rem_t;
      root_r     <= {root_r[MAG_W-2:0], sq_ge};
    end
    if (cmd.out_load) begin
      out_std_r  <= sts.full ? std_sat : '0;
      out_full_r <= sts.full;
    end
  end

  a_fill_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= win_len)
    else $error("fill count beyond window length");

  a_slot_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.add_new |=> LEN_W'(write_slot_r) < win_len)
    else $error("write slot beyond window length");

endmodule

// File: hw/rtl/rolling_window_std_dev_core.sv
// A result is offered after the read, add and remove states while the window is filling;
// once it is full, the radix-4 divider runs twice (27 steps each) and the bit-serial root
// (24 steps) before the result. Only one item is in work at a time: in_ready is high only in
// idle, and the result waits in the finish state until the output register is free.
// Reset (rst_n low, synchronous): window_length returns to 114, sums, fill and slot clear;
// a window_length write clears the history the same way.
module rolling_window_std_dev_core import rwsd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [SAMP_W-1:0] in_sample,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [STD_W-1:0]         out_std_dev,
  output logic                     out_window_full,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready
);

  logic [WL_W-1:0]      window_length_r;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;
  rwsd_cmd_t            cmd;
  rwsd_sts_t            sts;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready && (reg_idx == REG_WINDOW_LENGTH);

  always_comb begin
    unique case (reg_idx)
      REG_WINDOW_LENGTH: prdata = DATA_W'(window_length_r);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_length_r <= WL_RESET;
    end else if (cfg_wr) begin
      window_length_r <= pwdata[WL_W-1:0];
    end
  end

  rwsd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  rwsd_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .clear           (cfg_wr),
    .window_length   (window_length_r),
    .in_sample       (in_sample),
    .cmd             (cmd),
    .sts             (sts),
    .out_std_dev     (out_std_dev),
    .out_window_full (out_window_full)
  );

  a_one_item_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second transfer taken while an item is in work");

endmodule

// File: sim/rolling_window_std_dev_core_tb.sv
`timescale 1ns / 1ps

module rolling_window_std_dev_core_tb;
  import rwsd_pkg::*;

  localparam logic [ADDR_W-1:0] WL_ADDR = {REG_WINDOW_LENGTH, 2'b00};
  localparam logic signed [SAMP_W-1:0] S_MIN = {1'b1, {(SAMP_W-1){1'b0}}};
  localparam logic signed [SAMP_W-1:0] S_MAX = {1'b0, {(SAMP_W-1){1'b1}}};

  class window_sd_tracker;
    logic signed [SAMP_W-1:0] hist [HIST_DEPTH];
    int unsigned head;
    int unsigned held;
    longint sum;
    longint unsigned sum_sq;
    logic [WL_W-1:0] wlen;
    logic [STD_W-1:0] want_sd [$];
    bit want_full [$];
    int mismatches;

    function new();
      wlen = WL_RESET;
      mismatches = 0;
      clear();
    endfunction

    function void clear();
      head = 0;
      held = 0;
      sum = 0;
      sum_sq = 0;
    endfunction

    function void set_length(logic [WL_W-1:0] v);
      wlen = v;
      clear();
    endfunction

    function int pending();
      return want_sd.size();
    endfunction

    function longint unsigned root(longint unsigned v);
      longint unsigned r;
      longint unsigned t;
      r = 0;
      for (int i = 31; i >= 0; i--) begin
        t = r | (64'd1 << i);
        if (t * t <= v) r = t;
      end
      return r;
    endfunction

    function void take_sample(logic signed [SAMP_W-1:0] x);
      int unsigned w;
      int unsigned s;
      longint xv;
      longint old;
      longint unsigned mean_sq;
      longint unsigned mag;
      longint unsigned mean;
      longint unsigned spread;
      longint unsigned sd;
      bit full;
      w = (wlen == 0) ? 1 : ((wlen > HIST_DEPTH) ? HIST_DEPTH : wlen);
      xv = x;
      s = (head >= w) ? 0 : head;
      if (held >= w) begin
        old = hist[s];
        sum -= old;
        sum_sq -= old * old;
        held = w;
      end else begin
        held++;
      end
      hist[s] = x;
      sum += xv;
      sum_sq += xv * xv;
      s++;
      head = (s >= w) ? 0 : s;
      full = (held >= w);
      sd = 0;
      if (full) begin
        mean_sq = sum_sq / w;
        mag = (sum < 0) ? -sum : sum;
        mean = mag / w;
        spread = (mean_sq > mean * mean) ? mean_sq - mean * mean : 0;
        sd = root(spread);
        if (sd > STD_MAX) sd = STD_MAX;
      end
      want_sd.insert(want_sd.size(), sd[STD_W-1:0]);
      want_full.insert(want_full.size(), full);
    endfunction

    function void check_result(logic [STD_W-1:0] sd, logic full);
      logic [STD_W-1:0] exp_sd;
      bit exp_full;
      if (want_sd.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, std_dev %0d window_full %0b", $time, sd, full);
        return;
      end
      exp_sd = want_sd.pop_front();
      exp_full = want_full.pop_front();
      if (sd !== exp_sd) begin
        mismatches++;
        $display("%0t: std_dev expected %0d actual %0d", $time, exp_sd, sd);
      end
      if (full !== exp_full) begin
        mismatches++;
        $display("%0t: window_full expected %0b actual %0b", $time, exp_full, full);
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [SAMP_W-1:0] in_sample = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [STD_W-1:0]         out_std_dev;
  logic                     out_window_full;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [ADDR_W-1:0]        paddr = '0;
  logic [DATA_W-1:0]        pwdata = '0;
  logic [DATA_W-1:0]        prdata;
  logic                     pready;

  window_sd_tracker board;
  bit gaps_on = 1'b1;
  int tx_gap_pct = 30;
  int rx_gap_pct = 30;

  rolling_window_std_dev_core dut (.*);

  always #10 clk = ~clk;

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // result sink stalls
  initial begin : sink
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (stall == 0 && gaps_on && $urandom_range(0, 99) < rx_gap_pct)
        stall = $urandom_range(1, 6);
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_result(out_std_dev, out_window_full);
  end

  task automatic send_sample(input logic signed [SAMP_W-1:0] x);
    if (gaps_on && $urandom_range(0, 99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= x;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.take_sample(x);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
  endtask

  task automatic read_length(input logic [WL_W-1:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= WL_ADDR;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== {{(DATA_W-WL_W){1'b0}}, v}) begin
      board.mismatches++;
      $display("%0t: window_length read expected %0d actual %0d", $time, v, prdata);
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // write, then read back in a back-to-back transfer
  task automatic write_length(input logic [WL_W-1:0] v);
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= WL_ADDR;
    pwdata <= ($urandom() & ~32'hFF) | DATA_W'(v);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    board.set_length(v);
    @(negedge clk);
    read_length(v);
  endtask

  function automatic logic signed [SAMP_W-1:0] pick_sample(logic signed [SAMP_W-1:0] centre);
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return SAMP_W'($urandom());
    if (r < 75) return centre + SAMP_W'($urandom_range(0, 511)) - SAMP_W'(256);
    if (r < 90) begin
      case ($urandom_range(0, 3))
        0: return S_MIN;
        1: return S_MAX;
        2: return '0;
        default: return '1;
      endcase
    end
    return centre;
  endfunction

  initial begin : main
    int n_items;
    int sent;
    int phase;
    int w;
    logic [WL_W-1:0] wl;
    logic signed [SAMP_W-1:0] centre;
    board = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    read_length(WL_RESET);

    send_sample(S_MIN);
    send_sample(S_MAX);
    send_sample('0);
    send_sample('1);
    send_sample(SAMP_W'(1));
    write_length(8'd1);
    send_sample(S_MAX);
    send_sample(S_MIN);
    write_length(8'd0);
    send_sample(SAMP_W'(1234));
    send_sample('1);
    write_length(8'd2);
    send_sample(S_MIN);
    send_sample(S_MAX);
    send_sample(S_MAX);
    send_sample(S_MIN);
    send_sample(S_MIN);
    send_sample(SAMP_W'(5));
    write_length(8'd3);
    repeat (3) send_sample(S_MIN);
    write_length(8'd255);
    send_sample(S_MAX);
    send_sample(S_MIN);
    write_length(8'd128);
    send_sample('1);
    send_sample(S_MAX);

    sent = 0;
    phase = 0;
    while (sent < 750) begin
      if (phase == 0) wl = 8'd255;
      else if (phase == 1) wl = 8'd129;
      else if ($urandom_range(0, 9) == 0) wl = WL_W'($urandom_range(64, 255));
      else wl = WL_W'($urandom_range(0, 20));
      w = (wl == 0) ? 1 : ((wl > HIST_DEPTH) ? HIST_DEPTH : wl);
      n_items = (phase < 2) ? w + $urandom_range(10, 30) : $urandom_range(1, w + 40);
      if (sent + n_items > 750) n_items = 750 - sent;
      case ($urandom_range(0, 2))
        0: tx_gap_pct = 0;
        1: tx_gap_pct = 25;
        default: tx_gap_pct = 60;
      endcase
      case ($urandom_range(0, 2))
        0: rx_gap_pct = 0;
        1: rx_gap_pct = 25;
        default: rx_gap_pct = 60;
      endcase
      write_length(wl);
      centre = SAMP_W'($urandom());
      repeat (n_items) begin
        if (750 - sent <= 60) gaps_on = 1'b0;
        if (sent == 400 || $urandom_range(0, 149) == 0) drain();
        send_sample(pick_sample(centre));
        sent++;
        if ($urandom_range(0, 31) == 0) centre = SAMP_W'($urandom());
      end
      phase++;
    end

    drain();
    repeat (100) @(negedge clk);
    if (board.mismatches == 0 && board.pending() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
